FILE: rtl/core/gbn_sender_congestion_window_core_macros.svh
// assertion macros used by the sender core controller
// no dependencies; taken in by `include
`ifndef GBN_SENDER_CONGESTION_WINDOW_CORE_MACROS_SVH
`define GBN_SENDER_CONGESTION_WINDOW_CORE_MACROS_SVH

// same-cycle implication under synchronous reset
`define GBN_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gbn core check failed");

// next-cycle implication under synchronous reset
`define GBN_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gbn core check failed");

`endif

FILE: rtl/core/gbn_pkg.sv
// types and constants of the go-back-n sender core
// no dependencies
`timescale 1ns / 1ps

package gbn_pkg;

    localparam int CFG_W = 24;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] CFG_MAX_WINDOW     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_INITIAL_CWND   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_INITIAL_SSTHR  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_MAX_RETRY      = 3'd3;
    localparam logic [IDX_W-1:0] CFG_SEG_SIZE       = 3'd4;

    localparam logic [1:0] REQ_START   = 2'd0;
    localparam logic [1:0] REQ_ACK     = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;

    localparam logic [1:0] STAT_PROGRESS  = 2'd0;
    localparam logic [1:0] STAT_ALL_ACKED = 2'd1;
    localparam logic [1:0] STAT_FAILED    = 2'd2;
    localparam logic [1:0] STAT_IDLE      = 2'd3;

    localparam logic [23:0] ONE_FX = 24'h01_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEG_DIV,
        ST_GROW,
        ST_RECIP,
        ST_CHECK,
        ST_PREP,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RUN,
        PH_DONE,
        PH_FAIL
    } phase_t;

    typedef struct packed {
        logic       load_in;
        logic       div_go;
        logic       div_recip;
        logic       start_init;
        logic       ack_upd;
        logic       grow_slow;
        logic       grow_aimd;
        logic       timeout_upd;
        logic       set_done;
        logic       set_fail;
        logic       prep;
        logic       prep_single;
        logic [1:0] prep_status;
        logic       out_fire;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        phase_t     phase;
        logic       ack_good;
        logic       retry_over;
        logic       cnt_zero;
        logic       slow;
        logic       div_done;
        logic       base_done;
        logic       out_last;
    } sts_t;

endpackage

FILE: rtl/core/gbn_sender_congestion_window_core.sv
// top level of the go-back-n sender with slow start and aimd window
// depends on gbn_pkg, gbn_ctrl, gbn_dpath (which holds gbn_div)
//
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+-----------------------------------------------
// s_       | in  | s_valid / s_ready  | req_type total_bytes ack_number peer_window ...
// m_       | out | m_valid / m_ready  | send_valid send_seq window_field status last
// cfg_     | in  | cfg_wr_en          | cfg_addr cfg_wdata
//
// one transaction at a time: decode and prep come first, then the results go out
// in order; a good ack adds its growth steps and a check state before prep
// a start runs all 33 quotient bits on the shared divider, then waits for done
// each acked segment in congestion avoidance runs a reciprocal in the same divider;
// slow start steps need no division; growth stops at the window cap
// synchronous active-low reset; results wait in place while m_ready is low
`timescale 1ns / 1ps

module gbn_sender_congestion_window_core #(
    parameter int MAX_WINDOW = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [gbn_pkg::IDX_W-1:0] cfg_addr,
    input  logic [gbn_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_req_type,
    input  logic [31:0]               s_total_bytes,
    input  logic [31:0]               s_ack_number,
    input  logic [15:0]               s_peer_window,
    input  logic                      s_check_ok,
    input  logic                      s_ack_flag,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_send_valid,
    output logic [31:0]               m_send_seq,
    output logic [5:0]                m_window_field,
    output logic [1:0]                m_status,
    output logic                      m_last
);
    import gbn_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencing
    gbn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // state and arithmetic
    gbn_dpath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_req_type     (s_req_type),
        .s_total_bytes  (s_total_bytes),
        .s_ack_number   (s_ack_number),
        .s_peer_window  (s_peer_window),
        .s_check_ok     (s_check_ok),
        .s_ack_flag     (s_ack_flag),
        .m_send_valid   (m_send_valid),
        .m_send_seq     (m_send_seq),
        .m_window_field (m_window_field),
        .m_status       (m_status),
        .m_last         (m_last),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

FILE: rtl/core/gbn_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// uses no package
`timescale 1ns / 1ps

module gbn_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        go,
    input  logic [32:0] dividend,
    input  logic [23:0] divisor,
    output logic        done,
    output logic [32:0] quotient,
    output logic        rem_nz
);

    localparam int STEPS = 33;

    logic [32:0] quo_reg, quo_next;
    logic [23:0] rem_reg, rem_next;
    logic [23:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [24:0] trial;
    logic        fits;

    // load on go, else one shift-subtract step while busy
    always_comb begin
        trial = {rem_reg, quo_reg[32]};
        fits  = trial >= {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (go) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 6'(STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? 24'(trial - {1'b0, dvs_reg}) : trial[23:0];
            quo_next = {quo_reg[31:0], fits};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control flops
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand flops
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_nz   = |rem_reg;

endmodule

FILE: rtl/core/gbn_ctrl.sv
// controller state machine of the sender core
// depends on gbn_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "gbn_sender_congestion_window_core_macros.svh"

module gbn_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  gbn_pkg::sts_t sts,
    output gbn_pkg::cmd_t cmd
);
    import gbn_pkg::*;

    state_t     state_reg, state_next;
    logic       single_reg, single_next;
    logic [1:0] stat_reg, stat_next;
    logic       not_run;

    assign not_run = sts.phase != PH_RUN;

    // state register and result mode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            single_reg <= 1'b0;
            stat_reg   <= STAT_PROGRESS;
        end else begin
            state_reg  <= state_next;
            single_reg <= single_next;
            stat_reg   <= stat_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_DECODE;
            ST_DECODE: begin
                if (sts.req == REQ_START) state_next = ST_SEG_DIV;
                else if (!not_run && sts.req == REQ_ACK && sts.ack_good) state_next = ST_GROW;
                else state_next = ST_PREP;
            end
            ST_SEG_DIV: if (sts.div_done) state_next = ST_PREP;
            ST_GROW: begin
                if (sts.cnt_zero) state_next = ST_CHECK;
                else if (!sts.slow) state_next = ST_RECIP;
            end
            ST_RECIP:   if (sts.div_done) state_next = ST_GROW;
            ST_CHECK:   state_next = ST_PREP;
            ST_PREP:    state_next = ST_EMIT;
            ST_EMIT:    if (m_ready && sts.out_last) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // result mode: single status result or window burst
    always_comb begin
        single_next = single_reg;
        stat_next   = stat_reg;
        if (state_reg == ST_DECODE) begin
            single_next = (sts.req != REQ_START) &&
                          (not_run || (sts.req == REQ_TIMEOUT && sts.retry_over));
            if (!not_run) stat_next = STAT_FAILED;
            else if (sts.phase == PH_DONE) stat_next = STAT_ALL_ACKED;
            else if (sts.phase == PH_FAIL) stat_next = STAT_FAILED;
            else stat_next = STAT_IDLE;
        end else if (state_reg == ST_CHECK) begin
            single_next = sts.base_done;
            stat_next   = STAT_ALL_ACKED;
        end
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_DECODE: begin
                if (sts.req == REQ_START) begin
                    cmd.div_go = 1'b1;
                end else if (!not_run && sts.req == REQ_ACK) begin
                    cmd.ack_upd = sts.ack_good;
                end else if (!not_run && sts.req == REQ_TIMEOUT) begin
                    cmd.set_fail    = sts.retry_over;
                    cmd.timeout_upd = !sts.retry_over;
                end
            end
            ST_SEG_DIV: cmd.start_init = sts.div_done;
            ST_GROW: begin
                if (!sts.cnt_zero) begin
                    cmd.grow_slow = sts.slow;
                    cmd.div_go    = !sts.slow;
                    cmd.div_recip = !sts.slow;
                end
            end
            ST_RECIP:   cmd.grow_aimd = sts.div_done;
            ST_CHECK:   cmd.set_done = sts.base_done;
            ST_PREP: begin
                cmd.prep        = 1'b1;
                cmd.prep_single = single_reg;
                cmd.prep_status = stat_reg;
            end
            ST_EMIT: begin
                m_valid      = 1'b1;
                cmd.out_fire = m_ready;
            end
            default: ;
        endcase
    end

    // checks
    `GBN_ASSERT_IMPL(a_ready_excl, aclk, aresetn, s_ready, !m_valid)
    `GBN_ASSERT_NEXT(a_accept_decode, aclk, aresetn, s_valid && s_ready,
                     state_reg == ST_DECODE)
    `GBN_ASSERT_NEXT(a_last_idle, aclk, aresetn, m_valid && m_ready && sts.out_last,
                     s_ready)
    `GBN_ASSERT_IMPL(a_div_single, aclk, aresetn, cmd.div_go,
                     state_reg == ST_DECODE || state_reg == ST_GROW)

endmodule

FILE: rtl/core/gbn_dpath.sv
// datapath: config, window state, growth arithmetic and result fields
// depends on gbn_pkg and gbn_div
`timescale 1ns / 1ps

module gbn_dpath #(
    parameter int MAX_WINDOW = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [gbn_pkg::IDX_W-1:0]   cfg_addr,
    input  logic [gbn_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic [1:0]                  s_req_type,
    input  logic [31:0]                 s_total_bytes,
    input  logic [31:0]                 s_ack_number,
    input  logic [15:0]                 s_peer_window,
    input  logic                        s_check_ok,
    input  logic                        s_ack_flag,
    output logic                        m_send_valid,
    output logic [31:0]                 m_send_seq,
    output logic [5:0]                  m_window_field,
    output logic [1:0]                  m_status,
    output logic                        m_last,
    input  gbn_pkg::cmd_t               cmd,
    output gbn_pkg::sts_t               sts
);
    import gbn_pkg::*;

    // configuration
    logic [5:0]  max_win_reg;
    logic [21:0] init_cwnd_reg;
    logic [23:0] init_ss_reg;
    logic [7:0]  max_retry_reg;
    logic [15:0] seg_size_reg;

    // latched transaction
    logic [1:0]  req_reg;
    logic [31:0] total_in_reg, ackn_reg;
    logic [15:0] pwin_reg;
    logic        ok_reg, aflag_reg;

    // window state
    logic [23:0] cwnd_reg, ss_reg;
    logic [15:0] recv_reg;
    logic [31:0] base_reg, nts_reg, segtot_reg, cnt_reg;
    logic [7:0]  retry_reg;
    phase_t      phase_reg;

    // emission state
    logic [6:0]  w_reg;
    logic [32:0] limit_reg;
    logic [4:0]  k_reg;
    logic        single_reg;
    logic [1:0]  ostat_reg;

    logic [6:0]  cap;
    logic [22:0] capfx;
    logic [7:0]  cw_int;
    logic [15:0] rw, e1;
    logic [6:0]  eff;
    logic        in_range;
    logic [33:0] nw_sum;
    logic [23:0] nw_cap;
    logic [23:0] half;
    logic [31:0] seg_n;
    logic        div_done, rem_nz;
    logic [32:0] quot, div_a;
    logic [23:0] div_b;
    logic        send_now;
    logic [32:0] nts_inc;

    // window cap and effective window
    always_comb begin
        cap = (max_win_reg == 6'd0) ? 7'd1 : {1'b0, max_win_reg};
        if (cap > 7'(MAX_WINDOW)) cap = 7'(MAX_WINDOW);
        capfx  = {cap, 16'h0000};
        cw_int = (cwnd_reg[23:16] == 8'd0) ? 8'd1 : cwnd_reg[23:16];
        rw     = (recv_reg == 16'd0) ? 16'd1 : recv_reg;
        e1     = ({8'd0, cw_int} < rw) ? {8'd0, cw_int} : rw;
        eff    = ({9'd0, cap} < e1) ? cap : e1[6:0];
    end

    // ack range, growth step, halved window and segment count
    always_comb begin
        in_range = (ackn_reg >= base_reg) && (ackn_reg < segtot_reg);
        nw_sum   = cmd.grow_aimd ? ({10'd0, cwnd_reg} + {1'b0, quot})
                                 : ({10'd0, cwnd_reg} + {10'd0, ONE_FX});
        nw_cap   = (nw_sum > {11'd0, capfx}) ? {1'b0, capfx} : nw_sum[23:0];
        half     = {1'b0, cwnd_reg[23:1]};
        seg_n    = quot[31:0] + {31'd0, rem_nz};
        if (seg_n == 32'd0) seg_n = 32'd1;
    end

    // shared divider: segment count or reciprocal of cwnd
    always_comb begin
        if (cmd.div_recip) begin
            div_a = 33'h1_0000_0000;
            div_b = (cwnd_reg == 24'd0) ? 24'd1 : cwnd_reg;
        end else begin
            div_a = {1'b0, total_in_reg};
            div_b = {8'd0, (seg_size_reg == 16'd0) ? 16'd1 : seg_size_reg};
        end
    end

    gbn_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (cmd.div_go),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (quot),
        .rem_nz   (rem_nz)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_win_reg   <= 6'd32;
            init_cwnd_reg <= 22'd65536;
            init_ss_reg   <= 24'd1048576;
            max_retry_reg <= 8'd5;
            seg_size_reg  <= 16'd1024;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MAX_WINDOW:    max_win_reg   <= cfg_wdata[5:0];
                CFG_INITIAL_CWND:  init_cwnd_reg <= cfg_wdata[21:0];
                CFG_INITIAL_SSTHR: init_ss_reg   <= cfg_wdata;
                CFG_MAX_RETRY:     max_retry_reg <= cfg_wdata[7:0];
                CFG_SEG_SIZE:      seg_size_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            req_reg      <= s_req_type;
            total_in_reg <= s_total_bytes;
            ackn_reg     <= s_ack_number;
            pwin_reg     <= s_peer_window;
            ok_reg       <= s_check_ok;
            aflag_reg    <= s_ack_flag;
        end
    end

    // window state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cwnd_reg   <= 24'd65536;
            ss_reg     <= 24'd1048576;
            recv_reg   <= 16'd16;
            base_reg   <= '0;
            nts_reg    <= '0;
            segtot_reg <= '0;
            cnt_reg    <= '0;
            retry_reg  <= '0;
            phase_reg  <= PH_IDLE;
            k_reg      <= '0;
            single_reg <= 1'b0;
            ostat_reg  <= STAT_PROGRESS;
        end else begin
            if (cmd.start_init) begin
                segtot_reg <= seg_n;
                cwnd_reg   <= {2'b00, init_cwnd_reg};
                ss_reg     <= init_ss_reg;
                recv_reg   <= {8'd0, init_ss_reg[23:16]};
                base_reg   <= '0;
                nts_reg    <= '0;
                retry_reg  <= '0;
                phase_reg  <= PH_RUN;
            end
            if (cmd.ack_upd) begin
                if (pwin_reg != 16'd0) recv_reg <= pwin_reg;
                if (in_range) begin
                    cnt_reg   <= ackn_reg + 32'd1 - base_reg;
                    base_reg  <= ackn_reg + 32'd1;
                    retry_reg <= '0;
                end else begin
                    cnt_reg <= '0;
                end
            end
            if (cmd.grow_slow || cmd.grow_aimd) begin
                cwnd_reg <= nw_cap;
                cnt_reg  <= (nw_cap == {1'b0, capfx}) ? 32'd0 : cnt_reg - 32'd1;
            end
            if (cmd.timeout_upd) begin
                retry_reg <= retry_reg + 8'd1;
                ss_reg    <= (half < ONE_FX) ? ONE_FX : half;
                cwnd_reg  <= ONE_FX;
                nts_reg   <= base_reg;
            end
            if (cmd.set_done) phase_reg <= PH_DONE;
            if (cmd.set_fail) phase_reg <= PH_FAIL;
            if (cmd.prep) begin
                k_reg      <= '0;
                single_reg <= cmd.prep_single;
                ostat_reg  <= cmd.prep_status;
                if (!cmd.prep_single && nts_reg < base_reg) nts_reg <= base_reg;
            end
            if (cmd.out_fire && send_now) begin
                nts_reg <= nts_inc[31:0];
                k_reg   <= k_reg + 5'd1;
            end
        end
    end

    // window snapshot for the burst
    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            w_reg     <= eff;
            limit_reg <= {1'b0, base_reg} + {26'd0, eff};
        end
    end

    // result fields
    always_comb begin
        nts_inc  = {1'b0, nts_reg} + 33'd1;
        send_now = !single_reg && (nts_reg < segtot_reg) && ({1'b0, nts_reg} < limit_reg);
        m_send_valid   = send_now;
        m_send_seq     = send_now ? nts_reg : 32'd0;
        m_window_field = w_reg[5:0];
        m_status       = single_reg ? ostat_reg : STAT_PROGRESS;
        m_last         = !send_now || (k_reg == 5'd31) ||
                         (nts_inc >= {1'b0, segtot_reg}) || (nts_inc >= limit_reg);
    end

    // status to the controller
    always_comb begin
        sts.req        = req_reg;
        sts.phase      = phase_reg;
        sts.ack_good   = ok_reg && aflag_reg;
        sts.retry_over = ({1'b0, retry_reg} + 9'd1) > {1'b0, max_retry_reg};
        sts.cnt_zero   = cnt_reg == 32'd0;
        sts.slow       = cwnd_reg < ss_reg;
        sts.div_done   = div_done;
        sts.base_done  = base_reg >= segtot_reg;
        sts.out_last   = m_last;
    end

endmodule

FILE: tb/sv/gbn_sender_congestion_window_core_tb.sv
// testbench for the go-back-n sender core: directed and random events
// checked against a behavioral window model; depends on gbn_pkg and the core
`timescale 1ns / 1ps

module gbn_sender_congestion_window_core_tb;
    import gbn_pkg::*;

    localparam int MAXW = 32;

    typedef struct packed {
        logic        send_valid;
        logic [31:0] send_seq;
        logic [5:0]  window_field;
        logic [1:0]  status;
        logic        last;
    } seg_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = '0;
    logic [31:0] s_total_bytes = '0;
    logic [31:0] s_ack_number = '0;
    logic [15:0] s_peer_window = '0;
    logic        s_check_ok = 1'b0;
    logic        s_ack_flag = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_send_valid;
    logic [31:0] m_send_seq;
    logic [5:0]  m_window_field;
    logic [1:0]  m_status;
    logic        m_last;

    gbn_sender_congestion_window_core #(.MAX_WINDOW(MAXW)) uut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // shadow registers and window state
    logic [5:0]  r_max_window = 6'd32;
    logic [21:0] r_init_cwnd = 22'd65536;
    logic [23:0] r_init_ssthr = 24'd1048576;
    logic [7:0]  r_max_retry = 8'd5;
    logic [15:0] r_seg_size = 16'd1024;
    logic [23:0] cwnd, ssthr;
    logic [15:0] rwin;
    logic [31:0] base, nxt, seg_total;
    logic [7:0]  retries;
    phase_t      phase;

    seg_out_t expected_segs[$];
    int mismatches = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;

    function automatic logic [31:0] cap_segs();
        logic [31:0] c;
        c = r_max_window;
        if (c < 1) c = 1;
        if (c > MAXW) c = MAXW;
        return c;
    endfunction

    function automatic logic [31:0] eff_win();
        logic [31:0] cw, rw, e;
        cw = cwnd >> 16;
        if (cw < 1) cw = 1;
        rw = (rwin == 0) ? 1 : rwin;
        e = cw;
        if (rw < e) e = rw;
        if (cap_segs() < e) e = cap_segs();
        return e;
    endfunction

    task automatic push_single(logic [1:0] st);
        seg_out_t r;
        logic [31:0] w;
        w = eff_win();
        r.send_valid = 1'b0;
        r.send_seq = '0;
        r.window_field = w[5:0];
        r.status = st;
        r.last = 1'b1;
        expected_segs = {expected_segs, r};
    endtask

    // release the segments that the window now admits
    task automatic push_window();
        logic [31:0] w;
        logic [32:0] lim;
        seg_out_t r;
        int k;
        k = 0;
        w = eff_win();
        lim = {1'b0, base} + {1'b0, w};
        if (nxt < base) nxt = base;
        while (k < 32 && nxt < seg_total && {1'b0, nxt} < lim) begin
            r.send_valid = 1'b1;
            r.send_seq = nxt;
            r.window_field = w[5:0];
            r.status = STAT_PROGRESS;
            r.last = 1'b0;
            expected_segs = {expected_segs, r};
            k++;
            nxt++;
        end
        if (k == 0) push_single(STAT_PROGRESS);
        else expected_segs[$].last = 1'b1;
    endtask

    task automatic grow_cwnd(logic [31:0] count);
        logic [31:0] capfx, d;
        logic [63:0] nw;
        capfx = cap_segs() * 65536;
        for (logic [31:0] i = 0; i < count; i++) begin
            if (cwnd < ssthr) nw = cwnd + 64'd65536;
            else begin
                d = (cwnd == 0) ? 1 : cwnd;
                nw = cwnd + (64'h1_0000_0000 / d);
            end
            if (nw > capfx) nw = capfx;
            cwnd = nw[23:0];
            if (cwnd == capfx) break;
        end
    endtask

    task automatic predict_event(logic [1:0] req, logic [31:0] tot, logic [31:0] ackn,
                                 logic [15:0] pwin, logic ok, logic aflag);
        logic [31:0] ss, n;
        logic [23:0] half;
        if (req == REQ_START) begin
            ss = (r_seg_size == 0) ? 1 : r_seg_size;
            n = tot / ss + ((tot % ss != 0) ? 1 : 0);
            if (n == 0) n = 1;
            seg_total = n;
            cwnd = {2'b00, r_init_cwnd};
            ssthr = r_init_ssthr;
            rwin = {8'd0, r_init_ssthr[23:16]};
            base = 0;
            nxt = 0;
            retries = 0;
            phase = PH_RUN;
            push_window();
        end else if (phase != PH_RUN) begin
            push_single(phase == PH_DONE ? STAT_ALL_ACKED :
                        phase == PH_FAIL ? STAT_FAILED : STAT_IDLE);
        end else if (req == REQ_ACK) begin
            if (ok && aflag) begin
                if (pwin != 0) rwin = pwin;
                if (ackn >= base && ackn < seg_total) begin
                    grow_cwnd(ackn + 1 - base);
                    base = ackn + 1;
                    retries = 0;
                end
            end
            if (ok && aflag && base >= seg_total) begin
                phase = PH_DONE;
                push_single(STAT_ALL_ACKED);
            end else push_window();
        end else if (req == REQ_TIMEOUT) begin
            if ({1'b0, retries} + 9'd1 > {1'b0, r_max_retry}) begin
                phase = PH_FAIL;
                push_single(STAT_FAILED);
            end else begin
                retries = retries + 8'd1;
                half = cwnd >> 1;
                ssthr = (half < ONE_FX) ? ONE_FX : half;
                cwnd = ONE_FX;
                nxt = base;
                push_window();
            end
        end else push_window();
    endtask

    task automatic model_reset();
        cwnd = {2'b00, r_init_cwnd};
        ssthr = r_init_ssthr;
        rwin = {8'd0, r_init_ssthr[23:16]};
        base = 0;
        nxt = 0;
        seg_total = 0;
        retries = 0;
        phase = PH_IDLE;
    endtask

    // send one event transaction and record what it should produce
    task automatic send_event(logic [1:0] req, logic [31:0] tot, logic [31:0] ackn,
                              logic [15:0] pwin, logic ok, logic aflag);
        @(posedge aclk);
        while ($urandom_range(99) < sender_idle_pct) @(posedge aclk);
        s_valid <= 1'b1;
        s_req_type <= req;
        s_total_bytes <= tot;
        s_ack_number <= ackn;
        s_peer_window <= pwin;
        s_check_ok <= ok;
        s_ack_flag <= aflag;
        predict_event(req, tot, ackn, pwin, ok, aflag);
        do @(posedge aclk); while (!s_ready);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_segs.size() != 0) @(posedge aclk);
        repeat (2500) @(posedge aclk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MAX_WINDOW:    r_max_window = val[5:0];
            CFG_INITIAL_CWND:  r_init_cwnd = val[21:0];
            CFG_INITIAL_SSTHR: r_init_ssthr = val[23:0];
            CFG_MAX_RETRY:     r_max_retry = val[7:0];
            CFG_SEG_SIZE:      r_seg_size = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [5:0] mw, logic [21:0] cw, logic [23:0] st,
                              logic [7:0] mr, logic [15:0] ss);
        write_reg(CFG_MAX_WINDOW, CFG_W'(mw));
        write_reg(CFG_INITIAL_CWND, CFG_W'(cw));
        write_reg(CFG_INITIAL_SSTHR, st);
        write_reg(CFG_MAX_RETRY, CFG_W'(mr));
        write_reg(CFG_SEG_SIZE, CFG_W'(ss));
    endtask

    // result receiver with random stalls
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        seg_out_t got, exp_r;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_send_valid, m_send_seq, m_window_field, m_status, m_last};
            if (expected_segs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                exp_r = expected_segs.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10) $display("expected %p got %p", exp_r, got);
                end
            end
        end
    end

    task automatic test_directed();
        send_event(REQ_ACK, 32'd0, 32'd0, 16'd5, 1'b1, 1'b1);
        send_event(REQ_START, 32'hFFFF_FFFF, 32'd0, 16'd0, 1'b0, 1'b0);
        send_event(REQ_ACK, 32'd0, 32'd3, 16'hFFFF, 1'b1, 1'b1);
        send_event(REQ_ACK, 32'd0, 32'd9, 16'd7, 1'b0, 1'b1);
        send_event(REQ_ACK, 32'd0, 32'd9, 16'd7, 1'b1, 1'b0);
        send_event(2'd3, 32'd0, 32'd0, 16'd0, 1'b1, 1'b1);
        send_event(REQ_ACK, 32'd0, 32'd2, 16'd4, 1'b1, 1'b1);
        send_event(REQ_ACK, 32'd0, 32'hFFFF_FFFF, 16'd0, 1'b1, 1'b1);
        send_event(REQ_TIMEOUT, 32'd0, 32'd0, 16'd0, 1'b0, 1'b0);
        send_event(REQ_ACK, 32'd0, 32'd40, 16'd0, 1'b1, 1'b1);
        send_event(REQ_START, 32'd0, 32'd0, 16'd0, 1'b0, 1'b0);
        send_event(REQ_ACK, 32'd0, 32'd0, 16'd0, 1'b1, 1'b1);
        send_event(REQ_ACK, 32'd0, 32'd0, 16'd0, 1'b1, 1'b1);
        send_event(REQ_TIMEOUT, 32'd0, 32'd0, 16'd0, 1'b1, 1'b1);
        send_event(REQ_START, 32'd5000, 32'd0, 16'd0, 1'b0, 1'b0);
        repeat (7) send_event(REQ_TIMEOUT, 32'd0, 32'd0, 16'd0, 1'b0, 1'b0);
        send_event(2'd3, 32'd0, 32'd0, 16'd0, 1'b0, 1'b0);
        wait_drained();
    endtask

    task automatic test_edge_config();
        // zero sizes, smallest window, zero retries, tiny congestion window; then every field at its maximum
        set_config(6'd0, 22'd0, 24'd65536, 8'd0, 16'd0);
        send_event(REQ_START, 32'd3, 32'd0, 16'd0, 1'b1, 1'b1);
        send_event(REQ_ACK, 32'd0, 32'd0, 16'd0, 1'b1, 1'b1);
        send_event(REQ_TIMEOUT, 32'd0, 32'd0, 16'd0, 1'b1, 1'b1);
        wait_drained();
        set_config(6'd63, 22'h3F_FFFF, 24'hFF_FFFF, 8'd255, 16'hFFFF);
        send_event(REQ_START, 32'hFFFF_FFFF, 32'd0, 16'd0, 1'b1, 1'b1);
        send_event(REQ_ACK, 32'd0, 32'd20, 16'd40, 1'b1, 1'b1);
        send_event(REQ_TIMEOUT, 32'd0, 32'd0, 16'd0, 1'b1, 1'b1);
        wait_drained();
    endtask

    // mostly well-formed transfers with random acks, timeouts and noise
    task automatic test_random(int items);
        logic [31:0] a;
        int sel, k;
        k = 0;
        while (k < items) begin
            sel = $urandom_range(99);
            if (phase != PH_RUN || sel < 6)
                send_event(REQ_START, ($urandom_range(3) == 0) ? $urandom :
                           $urandom_range(40000), $urandom, 16'($urandom),
                           1'($urandom), 1'($urandom));
            else if (sel < 75) begin
                a = ($urandom_range(9) == 0) ? $urandom :
                    base + $urandom_range(4) - 1;
                send_event(REQ_ACK, $urandom, a,
                           ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(40)),
                           $urandom_range(9) != 0, $urandom_range(9) != 0);
            end else if (sel < 95)
                send_event(REQ_TIMEOUT, $urandom, $urandom, 16'($urandom),
                           1'($urandom), 1'($urandom));
            else
                send_event(2'd3, $urandom, $urandom, 16'($urandom),
                           1'($urandom), 1'($urandom));
            k++;
        end
        wait_drained();
    endtask

    initial begin
        model_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        sender_idle_pct = 6;
        receiver_idle_pct = 75;
        test_directed();
        test_edge_config();
        set_config(6'd8, 22'd131072, 24'd262144, 8'd3, 16'd512);
        test_random(80);
        sender_idle_pct = 75;
        receiver_idle_pct = 6;
        set_config(6'd32, 22'd65536, 24'd1048576, 8'd5, 16'd1024);
        test_random(80);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        set_config(6'd17, 22'd200000, 24'd400000, 8'd2, 16'd100);
        test_random(80);
        if (mismatches == 0 && expected_segs.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #200ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/gbn_pkg.sv
rtl/core/gbn_div.sv
rtl/core/gbn_ctrl.sv
rtl/core/gbn_dpath.sv
rtl/core/gbn_sender_congestion_window_core.sv
tb/sv/gbn_sender_congestion_window_core_tb.sv
